FILE: src/key_id_lifecycle_allocator_core_macros.svh
// assertion macros for the key id allocator
// used by key_id_lifecycle_allocator_core, expects clk and rst_n in scope
`ifndef KEY_ID_LIFECYCLE_ALLOCATOR_CORE_MACROS_SVH
`define KEY_ID_LIFECYCLE_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define KILA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kila assertion failed");

// next-cycle implication
`define KILA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kila assertion failed");

`endif

FILE: src/kila_pkg.sv
// shared types and constants for the key id allocator
// no dependencies
package kila_pkg;

    localparam int ID_W     = 6;
    localparam int ID_DEPTH = 2 ** ID_W;
    localparam int TAG_BITS = 32;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [ID_W-1:0] MAX_IDS = ID_W'(63);

    localparam logic [CFG_IDX_W-1:0] CFG_IDS_IN_USE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = CFG_IDX_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_RESERVE     = 3'd0,
        OP_LOOKUP      = 3'd1,
        OP_REMOVE      = 3'd2,
        OP_REF_RELEASE = 3'd3,
        OP_CLEAR       = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ID_AVAIL    = 2'd0,
        ID_ASSIGNED = 2'd1,
        ID_KILLED   = 2'd2,
        ID_RELEASED = 2'd3
    } id_st_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NONE     = 2'd1,
        STS_DISABLED = 2'd2,
        STS_INVALID  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_WAIT = 3'b100
    } fsm_t;

endpackage

FILE: src/key_id_lifecycle_allocator_core.sv
// key id lifecycle allocator: id table with state, tag and first-free scan
// depends on kila_pkg and key_id_lifecycle_allocator_core_macros.svh
// path: disabled, unknown op, bad ref-release id or empty pool go from the input beat to
// S_WAIT, then to the output register when not stalled; scanning ops check one entry a cycle
// throughput: one beat per op, next beat taken the cycle after the result is registered
// reset: async active low, all ids available, ids_in_use 63, enable 0
`include "key_id_lifecycle_allocator_core_macros.svh"

module key_id_lifecycle_allocator_core
    import kila_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OP_W-1:0]       op,
    input  logic [TAG_BITS-1:0]   key_tag,
    input  logic [ID_W-1:0]       key_id,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ID_W-1:0]       result_id,
    output logic [1:0]            status,
    output logic [ID_W-1:0]       freed_count,
    output logic [ID_W-1:0]       free_ids,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    fsm_t                state_reg, state_next;
    logic [ID_W-1:0]     ids_in_use_reg, ids_in_use_next;
    logic                enable_reg, enable_next;
    logic [ID_W-1:0]     free_count_reg, free_count_next;
    logic [ID_DEPTH-1:0] st_vld_reg, st_vld_next;
    logic [ID_DEPTH-1:0] tag_vld_reg, tag_vld_next;

    op_t                 op_reg, op_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic [ID_W:0]       rd_addr_reg, rd_addr_next;
    logic [ID_W-1:0]     end_reg, end_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [ID_W-1:0]     chk_addr_reg, chk_addr_next;
    logic [ID_W-1:0]     rid_reg, rid_next;
    status_t             sts_reg, sts_next;
    logic [ID_W-1:0]     freed_reg, freed_next;

    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_rid_reg, out_rid_next;
    logic [1:0]          out_sts_reg, out_sts_next;
    logic [ID_W-1:0]     out_freed_reg, out_freed_next;
    logic [ID_W-1:0]     out_free_reg, out_free_next;

    logic [ST_W-1:0]     st_mem [ID_DEPTH];
    logic [TAG_BITS-1:0] tag_mem [ID_DEPTH];
    logic [ST_W-1:0]     st_rdata_reg;
    logic [TAG_BITS-1:0] tag_rdata_reg;

    logic                st_we;
    logic [ST_W-1:0]     st_wdata;
    logic                tag_we;

    logic [ID_W-1:0]     lim;
    logic [ID_W-1:0]     cfg_lim;
    logic                in_accept;
    logic                issue;
    id_st_t              eff_st;
    logic                tag_hit;
    logic                hit_stop;
    logic                rel_hit;

    assign lim       = (ids_in_use_reg > MAX_IDS) ? MAX_IDS : ids_in_use_reg;
    assign cfg_lim   = (cfg_data[ID_W-1:0] > MAX_IDS) ? MAX_IDS : cfg_data[ID_W-1:0];
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign issue     = (state_reg == S_SCAN) && (rd_addr_reg <= {1'b0, end_reg});

    assign eff_st  = st_vld_reg[chk_addr_reg] ? id_st_t'(st_rdata_reg) : ID_AVAIL;
    assign tag_hit = tag_vld_reg[chk_addr_reg] && (tag_rdata_reg == tag_reg);

    always_comb
    begin
        hit_stop = 1'b0;
        rel_hit  = 1'b0;
        if (state_reg == S_SCAN && chk_vld_reg)
        begin
            case (op_reg)
                OP_RESERVE:     hit_stop = (eff_st == ID_AVAIL);
                OP_LOOKUP,
                OP_REMOVE:      hit_stop = tag_hit;
                OP_REF_RELEASE: hit_stop = (eff_st == ID_KILLED);
                OP_CLEAR:       rel_hit  = (eff_st == ID_RELEASED);
                default:        hit_stop = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        ids_in_use_next = ids_in_use_reg;
        enable_next     = enable_reg;
        free_count_next = free_count_reg;
        st_vld_next     = st_vld_reg;
        tag_vld_next    = tag_vld_reg;
        op_next         = op_reg;
        tag_next        = tag_reg;
        rd_addr_next    = rd_addr_reg;
        end_next        = end_reg;
        chk_vld_next    = 1'b0;
        chk_addr_next   = chk_addr_reg;
        rid_next        = rid_reg;
        sts_next        = sts_reg;
        freed_next      = freed_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_rid_next    = out_rid_reg;
        out_sts_next    = out_sts_reg;
        out_freed_next  = out_freed_reg;
        out_free_next   = out_free_reg;
        st_we           = 1'b0;
        st_wdata        = ID_AVAIL;
        tag_we          = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_IDS_IN_USE)
            begin
                ids_in_use_next = cfg_data[ID_W-1:0];
                st_vld_next     = '0;
                tag_vld_next    = '0;
                free_count_next = cfg_lim;
            end
            else if (cfg_index == CFG_ENABLE)
            begin
                enable_next = cfg_data[0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    op_next      = op_t'(op);
                    tag_next     = key_tag;
                    rid_next     = '0;
                    freed_next   = '0;
                    rd_addr_next = (ID_W+1)'(1);
                    end_next     = lim;
                    state_next   = S_SCAN;
                    if (!enable_reg)
                    begin
                        sts_next   = STS_DISABLED;
                        state_next = S_WAIT;
                    end
                    else
                    begin
                        case (op_t'(op))
                            OP_RESERVE:
                            begin
                                sts_next = STS_NONE;
                                if (free_count_reg == '0)
                                begin
                                    state_next = S_WAIT;
                                end
                            end
                            OP_LOOKUP,
                            OP_REMOVE:
                            begin
                                sts_next = STS_NONE;
                            end
                            OP_REF_RELEASE:
                            begin
                                sts_next     = STS_INVALID;
                                rd_addr_next = {1'b0, key_id};
                                end_next     = key_id;
                                if (key_id == '0 || key_id > lim)
                                begin
                                    state_next = S_WAIT;
                                end
                            end
                            OP_CLEAR:
                            begin
                                sts_next = STS_OK;
                            end
                            default:
                            begin
                                sts_next   = STS_INVALID;
                                state_next = S_WAIT;
                            end
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                chk_vld_next  = issue;
                chk_addr_next = rd_addr_reg[ID_W-1:0];
                rd_addr_next  = rd_addr_reg + 1'b1;
                if (hit_stop)
                begin
                    chk_vld_next = 1'b0;
                    rid_next     = chk_addr_reg;
                    sts_next     = STS_OK;
                    state_next   = S_WAIT;
                    case (op_reg)
                        OP_RESERVE:
                        begin
                            st_we        = 1'b1;
                            st_wdata     = ID_ASSIGNED;
                            tag_we       = 1'b1;
                            st_vld_next[chk_addr_reg]  = 1'b1;
                            tag_vld_next[chk_addr_reg] = 1'b1;
                            free_count_next = free_count_reg - 1'b1;
                        end
                        OP_REMOVE:
                        begin
                            st_we        = 1'b1;
                            st_wdata     = ID_KILLED;
                            st_vld_next[chk_addr_reg]  = 1'b1;
                            tag_vld_next[chk_addr_reg] = 1'b0;
                        end
                        OP_REF_RELEASE:
                        begin
                            st_we        = 1'b1;
                            st_wdata     = ID_RELEASED;
                            st_vld_next[chk_addr_reg]  = 1'b1;
                        end
                        default:
                        begin
                            st_we = 1'b0;
                        end
                    endcase
                end
                else
                begin
                    if (rel_hit)
                    begin
                        st_vld_next[chk_addr_reg]  = 1'b0;
                        tag_vld_next[chk_addr_reg] = 1'b0;
                        free_count_next = free_count_reg + 1'b1;
                        freed_next      = freed_reg + 1'b1;
                    end
                    if (!chk_vld_reg && !issue)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_rid_next   = rid_reg;
                    out_sts_next   = sts_reg;
                    out_freed_next = freed_reg;
                    out_free_next  = free_count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[chk_addr_reg] <= st_wdata;
        end
        if (tag_we)
        begin
            tag_mem[chk_addr_reg] <= tag_reg;
        end
        st_rdata_reg  <= st_mem[rd_addr_reg[ID_W-1:0]];
        tag_rdata_reg <= tag_mem[rd_addr_reg[ID_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ids_in_use_reg <= MAX_IDS;
            enable_reg     <= 1'b0;
            free_count_reg <= MAX_IDS;
            st_vld_reg     <= '0;
            tag_vld_reg    <= '0;
            chk_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ids_in_use_reg <= ids_in_use_next;
            enable_reg     <= enable_next;
            free_count_reg <= free_count_next;
            st_vld_reg     <= st_vld_next;
            tag_vld_reg    <= tag_vld_next;
            chk_vld_reg    <= chk_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        tag_reg       <= tag_next;
        rd_addr_reg   <= rd_addr_next;
        end_reg       <= end_next;
        chk_addr_reg  <= chk_addr_next;
        rid_reg       <= rid_next;
        sts_reg       <= sts_next;
        freed_reg     <= freed_next;
        out_rid_reg   <= out_rid_next;
        out_sts_reg   <= out_sts_next;
        out_freed_reg <= out_freed_next;
        out_free_reg  <= out_free_next;
    end

    assign out_valid   = out_valid_reg;
    assign result_id   = out_rid_reg;
    assign status      = out_sts_reg;
    assign freed_count = out_freed_reg;
    assign free_ids    = out_free_reg;

    `KILA_ASSERT_IMP(a_free_le_lim, 1'b1, free_count_reg <= lim)
    `KILA_ASSERT_IMP(a_chk_in_scan, chk_vld_reg, state_reg == S_SCAN)
    `KILA_ASSERT_NXT(a_reserve_dec, hit_stop && op_reg == OP_RESERVE,
        free_count_reg == $past(free_count_reg) - 1'b1)
    `KILA_ASSERT_NXT(a_wait_to_out, state_reg == S_WAIT && state_next == S_IDLE,
        out_valid_reg)

endmodule

FILE: test/key_id_lifecycle_allocator_core_test.sv
// self-checking testbench for key_id_lifecycle_allocator_core: directed and random id table traffic
// holds a scoreboard class that tracks id states, tags and the free pool beat by beat
// depends on kila_pkg and the key_id_lifecycle_allocator_core rtl
module key_id_lifecycle_allocator_core_test
    import kila_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B  = CFG_IDX_W'(3);
    localparam logic [OP_W-1:0]      OP_FIRST_BAD = OP_CLEAR + 1'b1;
    localparam logic [OP_W-1:0]      OP_LAST_BAD  = '1;
    localparam int                   TAG_POOL_N   = 6;
    localparam int                   PHASES       = 12;

    typedef struct {
        logic [ID_W-1:0] result_id;
        status_t         status;
        logic [ID_W-1:0] freed_count;
        logic [ID_W-1:0] free_ids;
    } answer_t;

    class key_id_ledger;
        id_st_t                id_state [ID_DEPTH];
        logic [TAG_BITS-1:0]   id_tag   [ID_DEPTH];
        bit                    id_tagged[ID_DEPTH];
        logic [ID_W-1:0]       free_left;
        logic [ID_W-1:0]       id_count;
        bit                    enabled;
        logic [ID_W-1:0]       last_killed;
        int                    errors;
        answer_t               pending_answers[$];

        function new();
            id_count    = MAX_IDS;
            enabled     = 1'b0;
            last_killed = '0;
            errors      = 0;
            reset_table();
        endfunction

        function void reset_table();
            for (int i = 0; i < ID_DEPTH; i++)
            begin
                id_state[i]  = ID_AVAIL;
                id_tag[i]    = '0;
                id_tagged[i] = 1'b0;
            end
            free_left = id_count;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IDS_IN_USE)
            begin
                id_count = data[ID_W-1:0];
                reset_table();
            end
            else if (idx == CFG_ENABLE)
            begin
                enabled = data[0];
            end
        endfunction

        function void note_request(logic [OP_W-1:0] op_in, logic [TAG_BITS-1:0] tag_in,
                                   logic [ID_W-1:0] id_in);
            answer_t a;
            a.result_id   = '0;
            a.status      = STS_OK;
            a.freed_count = '0;
            if (!enabled)
            begin
                a.status = STS_DISABLED;
            end
            else
            begin
                case (op_in)
                    OP_RESERVE:
                    begin
                        a.status = STS_NONE;
                        if (free_left != 0)
                        begin
                            for (int i = 1; i <= id_count; i++)
                            begin
                                if (id_state[i] == ID_AVAIL)
                                begin
                                    id_state[i]  = ID_ASSIGNED;
                                    id_tag[i]    = tag_in;
                                    id_tagged[i] = 1'b1;
                                    free_left    = free_left - 1'b1;
                                    a.result_id  = ID_W'(i);
                                    a.status     = STS_OK;
                                    break;
                                end
                            end
                        end
                    end
                    OP_LOOKUP, OP_REMOVE:
                    begin
                        a.status = STS_NONE;
                        for (int i = 1; i <= id_count; i++)
                        begin
                            if (id_tagged[i] && id_tag[i] == tag_in)
                            begin
                                a.result_id = ID_W'(i);
                                a.status    = STS_OK;
                                break;
                            end
                        end
                        if (op_in == OP_REMOVE && a.result_id != 0)
                        begin
                            id_tag[a.result_id]    = '0;
                            id_tagged[a.result_id] = 1'b0;
                            id_state[a.result_id]  = ID_KILLED;
                            last_killed            = a.result_id;
                        end
                    end
                    OP_REF_RELEASE:
                    begin
                        if (id_in >= 1 && id_in <= id_count && id_state[id_in] == ID_KILLED)
                        begin
                            id_state[id_in] = ID_RELEASED;
                            a.result_id     = id_in;
                        end
                        else
                        begin
                            a.status = STS_INVALID;
                        end
                    end
                    OP_CLEAR:
                    begin
                        for (int i = 1; i <= id_count; i++)
                        begin
                            if (id_state[i] == ID_RELEASED)
                            begin
                                id_state[i]   = ID_AVAIL;
                                id_tag[i]     = '0;
                                id_tagged[i]  = 1'b0;
                                free_left     = free_left + 1'b1;
                                a.freed_count = a.freed_count + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        a.status = STS_INVALID;
                    end
                endcase
            end
            a.free_ids = free_left;
            pending_answers.push_back(a);
        endfunction

        function void check_answer(logic [ID_W-1:0] rid, logic [1:0] sts,
                                   logic [ID_W-1:0] freed, logic [ID_W-1:0] free);
            answer_t a;
            if (pending_answers.size() == 0)
            begin
                $error("result beat with no request outstanding");
                errors++;
                return;
            end
            a = pending_answers.pop_front();
            if (rid !== a.result_id)
            begin
                $error("result_id: expected %0d, actual %0d", a.result_id, rid);
                errors++;
            end
            if (sts !== a.status)
            begin
                $error("status: expected %0d, actual %0d", a.status, sts);
                errors++;
            end
            if (freed !== a.freed_count)
            begin
                $error("freed_count: expected %0d, actual %0d", a.freed_count, freed);
                errors++;
            end
            if (free !== a.free_ids)
            begin
                $error("free_ids: expected %0d, actual %0d", a.free_ids, free);
                errors++;
            end
        endfunction
    endclass

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       op          = '0;
    logic [TAG_BITS-1:0]   key_tag     = '0;
    logic [ID_W-1:0]       key_id      = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [ID_W-1:0]       result_id;
    logic [1:0]            status;
    logic [ID_W-1:0]       freed_count;
    logic [ID_W-1:0]       free_ids;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    key_id_ledger ledger = new();

    key_id_lifecycle_allocator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .key_tag     (key_tag),
        .key_id      (key_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_id   (result_id),
        .status      (status),
        .freed_count (freed_count),
        .free_ids    (free_ids),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                ledger.write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                ledger.note_request(op, key_tag, key_id);
            if (out_valid && !out_stall)
                ledger.check_answer(result_id, status, freed_count, free_ids);
        end
    end

    task automatic send_request(logic [OP_W-1:0] o, logic [TAG_BITS-1:0] t,
                                logic [ID_W-1:0] k);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        key_tag  <= t;
        key_id   <= k;
        @(posedge clk);
        while (!(in_valid && !in_stall))
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!(cfg_valid && cfg_ready))
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (ledger.pending_answers.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int                  sizes[PHASES] = '{63, 1, 4, 63, 2, 0, 7, 63, 3, 5, 63, 6};
        logic [TAG_BITS-1:0] tag_pool[TAG_POOL_N];
        logic [TAG_BITS-1:0] t;
        logic [ID_W-1:0]     k;
        logic [OP_W-1:0]     o;
        int                  r;
        int                  items;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled after reset
        send_request(OP_RESERVE, 32'hFFFF_FFFF, 6'h3F);
        send_request(OP_LAST_BAD, 32'h0, 6'h0);
        drain();
        write_register(CFG_ENABLE, 6'h3F);
        write_register(CFG_IDS_IN_USE, 6'd3);
        write_register(CFG_SPARE_A, CFG_DATA_W'($urandom()));
        write_register(CFG_SPARE_B, CFG_DATA_W'($urandom()));

        // fill a three entry pool with a duplicate tag
        send_request(OP_RESERVE, 32'h0, 6'h0);
        send_request(OP_RESERVE, 32'h0, 6'h3F);
        send_request(OP_RESERVE, 32'hFFFF_FFFF, 6'h0);
        send_request(OP_RESERVE, 32'h1234_5678, 6'h0);
        send_request(OP_LOOKUP, 32'h0, 6'h0);
        send_request(OP_LOOKUP, 32'h1234_5678, 6'h0);
        send_request(OP_REMOVE, 32'hDEAD_BEEF, 6'h0);
        send_request(OP_REMOVE, 32'h0, 6'h0);
        send_request(OP_LOOKUP, 32'h0, 6'h0);
        send_request(OP_REF_RELEASE, 32'h0, 6'd0);
        send_request(OP_REF_RELEASE, 32'h0, 6'h3F);
        send_request(OP_REF_RELEASE, 32'h0, 6'd2);
        send_request(OP_REF_RELEASE, 32'h0, 6'd1);
        send_request(OP_REF_RELEASE, 32'h0, 6'd1);
        send_request(OP_CLEAR, 32'h0, 6'h0);
        send_request(OP_CLEAR, 32'h0, 6'h0);
        send_request(OP_FIRST_BAD, 32'h0, 6'h0);
        send_request(OP_FIRST_BAD + 1'b1, 32'h0, 6'h0);
        send_request(OP_RESERVE, 32'hA5A5_5A5A, 6'h0);

        // empty pool
        drain();
        write_register(CFG_IDS_IN_USE, 6'd0);
        send_request(OP_RESERVE, 32'h0, 6'h0);
        send_request(OP_REF_RELEASE, 32'h0, 6'd1);
        send_request(OP_CLEAR, 32'h0, 6'h0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            if (ph % 2 == 0)
            begin
                write_register(CFG_IDS_IN_USE, CFG_DATA_W'(sizes[ph]));
                write_register(CFG_ENABLE, {(CFG_DATA_W-1)'($urandom()), 1'b1 ^ (ph == 9)});
            end
            else
            begin
                write_register(CFG_ENABLE, {(CFG_DATA_W-1)'($urandom()), 1'b1 ^ (ph == 9)});
                write_register(CFG_IDS_IN_USE, CFG_DATA_W'(sizes[ph]));
            end
            for (int i = 0; i < TAG_POOL_N; i++)
                tag_pool[i] = $urandom();
            tag_pool[0] = (ph % 2) ? '0 : '1;
            items = (sizes[ph] == 0 || ph == 9) ? 40 : 170;

            repeat (items)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)      o = OP_RESERVE;
                else if (r < 45) o = OP_LOOKUP;
                else if (r < 65) o = OP_REMOVE;
                else if (r < 85) o = OP_REF_RELEASE;
                else if (r < 95) o = OP_CLEAR;
                else             o = OP_W'($urandom_range(OP_FIRST_BAD, OP_LAST_BAD));

                if ($urandom_range(0, 99) < 85)
                    t = tag_pool[$urandom_range(0, TAG_POOL_N - 1)];
                else
                    t = $urandom();

                r = $urandom_range(0, 99);
                if (r < 50)      k = ledger.last_killed;
                else if (r < 85) k = ID_W'($urandom_range(0, sizes[ph] + 1));
                else             k = ID_W'($urandom());

                send_request(o, t, k);
            end
        end

        drain();
        repeat (80) @(posedge clk);
        if (ledger.errors == 0 && ledger.pending_answers.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #8ms;
        $display("FAILURE");
        $finish;
    end

endmodule
